/* rtl/pip_pkg.sv */
// ----------------------------------------------------------------------------
// pip_pkg
// shared types and constants of the point in polygon tester
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

  localparam int unsigned HELD_W   = 7;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QFILL_W  = $clog2(QDEPTH + 1);

  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TEST   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_TEST,
    OP_STATUS
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } st_e;

endpackage

`default_nettype wire

/* rtl/pip_front.sv */
// ----------------------------------------------------------------------------
// pip_front
// decodes each request and queues it for the polygon engine
// ----------------------------------------------------------------------------
`default_nettype none

module pip_front import pip_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [ACTION_W-1:0]           action_i,
  input  logic signed [COORD_WIDTH-1:0] x_coord_i,
  input  logic signed [COORD_WIDTH-1:0] y_coord_i,
  output logic                          cmd_vld_o,
  output op_e                           cmd_op_o,
  output logic signed [COORD_WIDTH-1:0] cmd_x_o,
  output logic signed [COORD_WIDTH-1:0] cmd_y_o,
  input  logic                          pop_i
);

  op_e                          op_q [QDEPTH];
  logic signed [COORD_WIDTH-1:0] x_q [QDEPTH];
  logic signed [COORD_WIDTH-1:0] y_q [QDEPTH];
  logic [QPTR_W-1:0]            wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]            rd_ptr_q, rd_ptr_d;
  logic [QFILL_W-1:0]           fill_q, fill_d;
  logic                         push;
  op_e                          op_dec;

  always_comb begin
    unique case (action_i)
      ACT_CLEAR:  op_dec = OP_CLEAR;
      ACT_APPEND: op_dec = OP_APPEND;
      ACT_TEST:   op_dec = OP_TEST;
      ACT_NONE:   op_dec = OP_STATUS;
      default:    op_dec = OP_STATUS;
    endcase
  end

  assign busy_o    = (fill_q == QFILL_W'(QDEPTH));
  assign push      = start_i && !busy_o;
  assign cmd_vld_o = (fill_q != '0);
  assign cmd_op_o  = op_q[rd_ptr_q];
  assign cmd_x_o   = x_q[rd_ptr_q];
  assign cmd_y_o   = y_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop_i})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_ptr_q] <= op_dec;
      x_q[wr_ptr_q]  <= x_coord_i;
      y_q[wr_ptr_q]  <= y_coord_i;
    end
  end

`ifndef SYNTH
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> fill_q != '0)
    else $error("request popped from empty queue");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == QFILL_W'(QDEPTH)) |=> !$past(push))
    else $error("request pushed into full queue");
`endif

endmodule

`default_nettype wire

/* rtl/pip_edge.sv */
// ----------------------------------------------------------------------------
// pip_edge
// three stage edge crossing pipeline with exact cross-multiplied compare
// ----------------------------------------------------------------------------
`default_nettype none

module pip_edge #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clr_i,
  input  logic                          vld_i,
  input  logic signed [COORD_WIDTH-1:0] xi_i,
  input  logic signed [COORD_WIDTH-1:0] yi_i,
  input  logic signed [COORD_WIDTH-1:0] xj_i,
  input  logic signed [COORD_WIDTH-1:0] yj_i,
  input  logic signed [COORD_WIDTH-1:0] tx_i,
  input  logic signed [COORD_WIDTH-1:0] ty_i,
  output logic                          busy_o,
  output logic                          inside_o
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * COORD_WIDTH + 3;

  logic signed [DW-1:0] dy_d, ey_d, a_d, b_d;
  logic [DW-1:0]        d_d, e_d;
  logic                 straddle;

  logic                 s1_hit_q, s2_hit_q;
  logic signed [DW-1:0] a_q, b_q;
  logic [DW-1:0]        d_q, e_q;
  logic signed [PW-1:0] lhs_q, rhs_q, lhs_d, rhs_d;
  logic                 inside_q, inside_d;

  assign straddle = (yi_i > ty_i) != (yj_i > ty_i);
  assign dy_d     = DW'(yj_i) - DW'(yi_i);
  assign ey_d     = DW'(ty_i) - DW'(yi_i);
  assign a_d      = DW'(tx_i) - DW'(xi_i);
  assign b_d      = DW'(xj_i) - DW'(xi_i);
  assign d_d      = dy_d[DW-1] ? DW'(-dy_d) : DW'(dy_d);
  assign e_d      = ey_d[DW-1] ? DW'(-ey_d) : DW'(ey_d);

  assign lhs_d = $signed(a_q) * $signed({1'b0, d_q});
  assign rhs_d = $signed(b_q) * $signed({1'b0, e_q});

  always_comb begin
    inside_d = inside_q;
    if (clr_i) begin
      inside_d = 1'b0;
    end else if (s2_hit_q && (lhs_q < rhs_q)) begin
      inside_d = !inside_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_hit_q <= 1'b0;
      s2_hit_q <= 1'b0;
      inside_q <= 1'b0;
    end else begin
      s1_hit_q <= vld_i && straddle;
      s2_hit_q <= s1_hit_q;
      inside_q <= inside_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    d_q   <= d_d;
    e_q   <= e_d;
    lhs_q <= lhs_d;
    rhs_q <= rhs_d;
  end

  assign busy_o   = s1_hit_q || s2_hit_q;
  assign inside_o = inside_q;

endmodule

`default_nettype wire

/* rtl/pip_back.sv */
// ----------------------------------------------------------------------------
// pip_back
// polygon engine: vertex memory, status, and the edge walk sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module pip_back import pip_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned COORD_WIDTH  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_vld_i,
  input  op_e                           cmd_op_i,
  input  logic signed [COORD_WIDTH-1:0] cmd_x_i,
  input  logic signed [COORD_WIDTH-1:0] cmd_y_i,
  output logic                          pop_o,
  output logic                          done_o,
  output logic                          inside_res_o,
  output logic [HELD_W-1:0]             vertices_held_o,
  output logic                          overflowed_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EXT_W  = (CNT_W > HELD_W) ? CNT_W : HELD_W;
  localparam int unsigned VW     = 2 * COORD_WIDTH;

  st_e                 state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                ovf_q, ovf_d;
  logic [ADDR_W-1:0]   idx_q, idx_d, last_q, last_d, rd_addr;
  logic                prime_q, prime_d;
  logic                rd_vld_q, rd_vld_d, rd_prime_q, rd_prime_d;
  logic                done_q, done_d;
  logic                res_inside_q, res_inside_d;
  logic [HELD_W-1:0]   res_held_q;
  logic                res_ovf_q;
  logic [EXT_W-1:0]    cnt_ext;
  logic                wr_en, tx_ld, edge_clr, edge_busy, edge_inside;

  logic [VW-1:0]                 vtx_mem_q [MAX_VERTICES];
  logic [VW-1:0]                 rd_data_q, prev_q;
  logic signed [COORD_WIDTH-1:0] tx_q, ty_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_vld_i && cmd_op_i == OP_TEST && count_q != '0) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (!prime_q && idx_q == last_q) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !edge_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o        = 1'b0;
    count_d      = count_q;
    ovf_d        = ovf_q;
    wr_en        = 1'b0;
    tx_ld        = 1'b0;
    edge_clr     = 1'b0;
    idx_d        = idx_q;
    last_d       = last_q;
    prime_d      = prime_q;
    rd_addr      = idx_q;
    rd_vld_d     = 1'b0;
    rd_prime_d   = 1'b0;
    done_d       = 1'b0;
    res_inside_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_vld_i) begin
          pop_o = 1'b1;
          unique case (cmd_op_i)
            OP_CLEAR: begin
              count_d = '0;
              ovf_d   = 1'b0;
              done_d  = 1'b1;
            end
            OP_APPEND: begin
              if (count_q < CNT_W'(MAX_VERTICES)) begin
                wr_en   = 1'b1;
                count_d = count_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
              done_d = 1'b1;
            end
            OP_TEST: begin
              if (count_q == '0) begin
                done_d = 1'b1;
              end else begin
                tx_ld    = 1'b1;
                edge_clr = 1'b1;
                prime_d  = 1'b1;
                idx_d    = '0;
                last_d   = ADDR_W'(count_q - 1'b1);
              end
            end
            OP_STATUS: done_d = 1'b1;
            default:   done_d = 1'b1;
          endcase
        end
      end
      ST_WALK: begin
        rd_vld_d   = 1'b1;
        rd_prime_d = prime_q;
        rd_addr    = prime_q ? last_q : idx_q;
        if (prime_q) begin
          prime_d = 1'b0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !edge_busy) begin
          done_d       = 1'b1;
          res_inside_d = edge_inside;
        end
      end
      default: done_d = 1'b0;
    endcase
  end

  assign cnt_ext = EXT_W'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      ovf_q      <= 1'b0;
      idx_q      <= '0;
      last_q     <= '0;
      prime_q    <= 1'b0;
      rd_vld_q   <= 1'b0;
      rd_prime_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      ovf_q      <= ovf_d;
      idx_q      <= idx_d;
      last_q     <= last_d;
      prime_q    <= prime_d;
      rd_vld_q   <= rd_vld_d;
      rd_prime_q <= rd_prime_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      vtx_mem_q[count_q[ADDR_W-1:0]] <= {cmd_x_i, cmd_y_i};
    end
    rd_data_q <= vtx_mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) prev_q <= rd_data_q;
    if (tx_ld) begin
      tx_q <= cmd_x_i;
      ty_q <= cmd_y_i;
    end
    if (done_d) begin
      res_inside_q <= res_inside_d;
      res_held_q   <= cnt_ext[HELD_W-1:0];
      res_ovf_q    <= ovf_d;
    end
  end

  pip_edge #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_edge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (edge_clr),
    .vld_i    (rd_vld_q && !rd_prime_q),
    .xi_i     ($signed(rd_data_q[VW-1:COORD_WIDTH])),
    .yi_i     ($signed(rd_data_q[COORD_WIDTH-1:0])),
    .xj_i     ($signed(prev_q[VW-1:COORD_WIDTH])),
    .yj_i     ($signed(prev_q[COORD_WIDTH-1:0])),
    .tx_i     (tx_q),
    .ty_i     (ty_q),
    .busy_o   (edge_busy),
    .inside_o (edge_inside)
  );

  assign done_o          = done_q;
  assign inside_res_o    = res_inside_q;
  assign vertices_held_o = res_held_q;
  assign overflowed_o    = res_ovf_q;

`ifndef SYNTH
  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> count_q != '0)
    else $error("edge walk with empty polygon");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> count_q == CNT_W'(MAX_VERTICES))
    else $error("overflow flag set while polygon not full");

  a_rd_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q == ST_WALK))
    else $error("vertex read outside edge walk");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond capacity");
`endif

endmodule

`default_nettype wire

/* rtl/point_in_polygon_test_top.sv */
// ----------------------------------------------------------------------------
// point_in_polygon_test_top: clear, append and status results pass through the request queue and the done register
// test result follows an edge walk over the n stored vertices (no walk if n is 0), one read per cycle
// two-request queue; busy_o high while it is full; results strobed, never stalled
// asynchronous active-low reset empties the polygon, the queue and the overflow flag
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_test_top import pip_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned COORD_WIDTH  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [ACTION_W-1:0]           action_i,
  input  logic signed [COORD_WIDTH-1:0] x_coord_i,
  input  logic signed [COORD_WIDTH-1:0] y_coord_i,
  output logic                          done_o,
  output logic                          inside_res_o,
  output logic [HELD_W-1:0]             vertices_held_o,
  output logic                          overflowed_o
);

  logic                          cmd_vld, pop;
  op_e                           cmd_op;
  logic signed [COORD_WIDTH-1:0] cmd_x, cmd_y;

  pip_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .action_i  (action_i),
    .x_coord_i (x_coord_i),
    .y_coord_i (y_coord_i),
    .cmd_vld_o (cmd_vld),
    .cmd_op_o  (cmd_op),
    .cmd_x_o   (cmd_x),
    .cmd_y_o   (cmd_y),
    .pop_i     (pop)
  );

  pip_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_vld_i       (cmd_vld),
    .cmd_op_i        (cmd_op),
    .cmd_x_i         (cmd_x),
    .cmd_y_i         (cmd_y),
    .pop_o           (pop),
    .done_o          (done_o),
    .inside_res_o    (inside_res_o),
    .vertices_held_o (vertices_held_o),
    .overflowed_o    (overflowed_o)
  );

endmodule

`default_nettype wire
